### rtl/kvd_pkg.sv
package kvd_pkg;

  localparam logic [2:0] ROLE_SUM = 3'd0;
  localparam logic [2:0] ROLE_LEN = 3'd1;
  localparam logic [2:0] ROLE_KEY = 3'd2;
  localparam logic [2:0] ROLE_VAL = 3'd3;
  localparam logic [2:0] ROLE_IGN = 3'd4;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       log_start;
    logic       log_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] byte_role;
    logic       record_done;
    logic       record_good;
    logic       truncated;
  } out_item_t;

endpackage

### rtl/kvd_crc_byte.sv
module kvd_crc_byte (
  input  logic [31:0] crc,
  input  logic [7:0]  data,
  output logic [31:0] crc_next
);
  import kvd_pkg::*;

  logic [31:0] c;

  always_comb begin
    c = crc ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    crc_next = c;
  end

endmodule

### rtl/kvd_parser.sv
module kvd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  kvd_pkg::in_item_t item,
  output kvd_pkg::out_item_t result
);
  import kvd_pkg::*;

  typedef enum logic [2:0] {
    PH_SUM  = 3'd0,
    PH_KLEN = 3'd1,
    PH_KEY  = 3'd2,
    PH_VLEN = 3'd3,
    PH_VAL  = 3'd4
  } phase_t;

  phase_t      phase, phase_cur, phase_next;
  logic [1:0]  word_idx, word_idx_cur, word_idx_next;
  logic [31:0] bytes_left, bytes_left_cur, bytes_left_next;
  logic [31:0] len_word, len_word_cur, len_word_next;
  logic [31:0] stored_sum, stored_sum_cur, stored_sum_next;
  logic [31:0] crc, crc_cur, crc_next;
  logic        halted, halted_cur, halted_next;

  logic [31:0] crc_upd;
  logic [31:0] put_word;
  logic [31:0] put_sum;
  logic [31:0] dec;
  logic        last;
  logic        done;
  logic        good;
  logic [2:0]  role;

  kvd_crc_byte u_crc (
    .crc      (crc_cur),
    .data     (item.in_byte),
    .crc_next (crc_upd)
  );

  always_comb begin
    if (item.log_start) begin
      phase_cur      = PH_SUM;
      word_idx_cur   = 2'd0;
      bytes_left_cur = 32'd0;
      len_word_cur   = 32'd0;
      stored_sum_cur = 32'd0;
      crc_cur        = CRC_INIT;
      halted_cur     = 1'b0;
    end else begin
      phase_cur      = phase;
      word_idx_cur   = word_idx;
      bytes_left_cur = bytes_left;
      len_word_cur   = len_word;
      stored_sum_cur = stored_sum;
      crc_cur        = crc;
      halted_cur     = halted;
    end
  end

  always_comb begin
    last     = (word_idx_cur == 2'd3);
    dec      = bytes_left_cur - 32'd1;
    put_word = ((word_idx_cur == 2'd0) ? 32'd0 : len_word_cur)
               | ({24'd0, item.in_byte} << {word_idx_cur, 3'b000});
    put_sum  = ((word_idx_cur == 2'd0) ? 32'd0 : stored_sum_cur)
               | ({24'd0, item.in_byte} << {word_idx_cur, 3'b000});

    phase_next      = phase_cur;
    word_idx_next   = word_idx_cur;
    bytes_left_next = bytes_left_cur;
    len_word_next   = len_word_cur;
    stored_sum_next = stored_sum_cur;
    crc_next        = crc_cur;
    halted_next     = halted_cur;
    role            = ROLE_IGN;
    done            = 1'b0;
    good            = 1'b0;

    if (!halted_cur) begin
      unique case (phase_cur)
        PH_SUM: begin
          role            = ROLE_SUM;
          stored_sum_next = put_sum;
          if (last) begin
            phase_next = PH_KLEN;
          end
        end
        PH_KLEN: begin
          role          = ROLE_LEN;
          crc_next      = crc_upd;
          len_word_next = put_word;
          if (last) begin
            bytes_left_next = put_word;
            phase_next      = (put_word == 32'd0) ? PH_VLEN : PH_KEY;
          end
        end
        PH_KEY: begin
          role            = ROLE_KEY;
          crc_next        = crc_upd;
          bytes_left_next = dec;
          if (dec == 32'd0) begin
            phase_next = PH_VLEN;
          end
        end
        PH_VLEN: begin
          role          = ROLE_LEN;
          crc_next      = crc_upd;
          len_word_next = put_word;
          if (last) begin
            bytes_left_next = put_word;
            if (put_word == 32'd0) begin
              done = 1'b1;
            end else begin
              phase_next = PH_VAL;
            end
          end
        end
        PH_VAL: begin
          role            = ROLE_VAL;
          crc_next        = crc_upd;
          bytes_left_next = dec;
          if (dec == 32'd0) begin
            done = 1'b1;
          end
        end
        default: begin
          phase_next    = PH_SUM;
          word_idx_next = 2'd0;
        end
      endcase

      if (role == ROLE_SUM || role == ROLE_LEN) begin
        word_idx_next = word_idx_cur + 2'd1;
      end

      if (done) begin
        good          = ((crc_next ^ CRC_INIT) == stored_sum_cur);
        crc_next      = CRC_INIT;
        phase_next    = PH_SUM;
        word_idx_next = 2'd0;
        if (!good) begin
          halted_next = 1'b1;
        end
      end
    end

    if (item.log_end) begin
      halted_next = 1'b1;
    end

    result.out_byte    = item.in_byte;
    result.byte_role   = role;
    result.record_done = done;
    result.record_good = done && good;
    result.truncated   = item.log_end && !halted_cur && !done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SUM;
      word_idx   <= 2'd0;
      bytes_left <= 32'd0;
      len_word   <= 32'd0;
      stored_sum <= 32'd0;
      crc        <= CRC_INIT;
      halted     <= 1'b0;
    end else if (fire) begin
      phase      <= phase_next;
      word_idx   <= word_idx_next;
      bytes_left <= bytes_left_next;
      len_word   <= len_word_next;
      stored_sum <= stored_sum_next;
      crc        <= crc_next;
      halted     <= halted_next;
    end
  end

endmodule

### rtl/kv_log_record_deframer_top.sv
// Log record deframer: takes one log byte per transaction and returns one
// tagged byte per transaction, with record_done/record_good on the byte that
// ends a record and truncated on a log_end byte inside an unfinished record.
// A byte passes through an input register and then a result register, and
// out_stall can hold it in the input register; one byte is taken every
// cycle as long as out_stall stays low, the per-byte CRC-32 update and length
// countdown both being combinational between the two registers.
module kv_log_record_deframer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  kvd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kvd_pkg::out_item_t out_data
);
  import kvd_pkg::*;

  in_item_t  s1_data;
  logic      s1_valid;
  out_item_t result;
  logic      out_ready;
  logic      accept;
  logic      fire;

  assign out_ready = !out_valid || !out_stall;
  assign fire      = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign accept    = in_valid && !in_stall;

  kvd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_data),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data <= in_data;
    end
    if (fire) begin
      out_data <= result;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_good_needs_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.record_good || out_data.record_done))
    else $error("record_good without record_done");

  a_done_role: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.record_done |->
      (out_data.byte_role == ROLE_LEN || out_data.byte_role == ROLE_VAL))
    else $error("record_done on a byte that cannot end a record");

  a_ignored_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_role == ROLE_IGN |->
      !out_data.record_done && !out_data.truncated)
    else $error("flags raised on an ignored byte");

endmodule

### dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kvd_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_BYTES = 1200;
  localparam int TAIL_CYCLES  = 8;

  typedef enum logic [2:0] {
    PH_CHECKSUM,
    PH_KEY_LEN,
    PH_KEY_BYTES,
    PH_VALUE_LEN,
    PH_VALUE_BYTES
  } parse_phase_e;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC,
    STALL_LONG
  } stall_mode_e;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  kv_log_record_deframer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  parse_phase_e phase;
  logic [1:0]   word_idx;
  logic [31:0]  payload_left;
  logic [31:0]  key_len;
  logic [31:0]  value_len;
  logic [31:0]  stored_crc;
  logic [31:0]  crc_acc;
  logic         halted;

  out_item_t expected_q[$];
  in_item_t  log_bytes[$];

  int errors        = 0;
  int burst_left    = 0;
  int total_bytes   = 0;
  int parsed_bytes  = 0;
  int records_good  = 0;
  int records_bad   = 0;
  int truncations   = 0;
  int cycle         = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] put_le_byte(input logic [31:0] word, input logic [1:0] idx,
                                              input logic [7:0] b);
    logic [31:0] w;
    w = (idx == 2'd0) ? 32'h0 : word;
    w[8*idx +: 8] = b;
    return w;
  endfunction

  function automatic void clear_parse_state();
    phase        = PH_CHECKSUM;
    word_idx     = 2'd0;
    payload_left = 32'h0;
    key_len      = 32'h0;
    value_len    = 32'h0;
    stored_crc   = 32'h0;
    crc_acc      = CRC_INIT;
    halted       = 1'b0;
  endfunction

  function automatic out_item_t deframe_byte(input in_item_t it);
    out_item_t r;
    logic      done;
    logic      good;
    logic      was_halted;
    logic      word_last;
    if (it.log_start) clear_parse_state();
    was_halted  = halted;
    done        = 1'b0;
    good        = 1'b0;
    r           = '0;
    r.out_byte  = it.in_byte;
    r.byte_role = ROLE_IGN;
    if (!halted) begin
      word_last = (word_idx == 2'd3);
      case (phase)
        PH_CHECKSUM: begin
          r.byte_role = ROLE_SUM;
          stored_crc  = put_le_byte(stored_crc, word_idx, it.in_byte);
          if (word_last) phase = PH_KEY_LEN;
        end
        PH_KEY_LEN: begin
          r.byte_role = ROLE_LEN;
          crc_acc     = crc32_byte(crc_acc, it.in_byte);
          key_len     = put_le_byte(key_len, word_idx, it.in_byte);
          if (word_last) begin
            payload_left = key_len;
            phase        = (key_len == 32'h0) ? PH_VALUE_LEN : PH_KEY_BYTES;
          end
        end
        PH_KEY_BYTES: begin
          r.byte_role = ROLE_KEY;
          crc_acc     = crc32_byte(crc_acc, it.in_byte);
          payload_left--;
          if (payload_left == 32'h0) phase = PH_VALUE_LEN;
        end
        PH_VALUE_LEN: begin
          r.byte_role = ROLE_LEN;
          crc_acc     = crc32_byte(crc_acc, it.in_byte);
          value_len   = put_le_byte(value_len, word_idx, it.in_byte);
          if (word_last) begin
            payload_left = value_len;
            if (value_len == 32'h0) done = 1'b1;
            else phase = PH_VALUE_BYTES;
          end
        end
        PH_VALUE_BYTES: begin
          r.byte_role = ROLE_VAL;
          crc_acc     = crc32_byte(crc_acc, it.in_byte);
          payload_left--;
          if (payload_left == 32'h0) done = 1'b1;
        end
        default: begin
          phase    = PH_CHECKSUM;
          word_idx = 2'd0;
        end
      endcase
      if (r.byte_role == ROLE_SUM || r.byte_role == ROLE_LEN) word_idx = word_idx + 2'd1;
      if (done) begin
        good     = ((~crc_acc) == stored_crc);
        crc_acc  = CRC_INIT;
        phase    = PH_CHECKSUM;
        word_idx = 2'd0;
        if (!good) halted = 1'b1;
      end
    end
    r.record_done = done;
    r.record_good = done & good;
    r.truncated   = it.log_end & ~was_halted & ~done;
    if (it.log_end) halted = 1'b1;
    return r;
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic ls, input logic le);
    in_item_t it;
    it.in_byte   = b;
    it.log_start = ls;
    it.log_end   = le;
    log_bytes.insert(log_bytes.size(), it);
  endfunction

  function automatic void push_le_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) push_byte(w[8*i +: 8], 1'b0, 1'b0);
  endfunction

  function automatic void append_record(input logic [31:0] klen, input logic [31:0] vlen,
                                        input logic corrupt);
    logic [7:0]  body[$];
    logic [31:0] crc;
    for (int i = 0; i < 4; i++) body.insert(body.size(), klen[8*i +: 8]);
    for (int i = 0; i < klen; i++) body.insert(body.size(), 8'($urandom_range(0, 255)));
    for (int i = 0; i < 4; i++) body.insert(body.size(), vlen[8*i +: 8]);
    for (int i = 0; i < vlen; i++) body.insert(body.size(), 8'($urandom_range(0, 255)));
    crc = CRC_INIT;
    foreach (body[i]) crc = crc32_byte(crc, body[i]);
    crc = ~crc;
    if (corrupt) crc = crc ^ (32'h1 << $urandom_range(0, 31));
    push_le_word(crc);
    foreach (body[i]) push_byte(body[i], 1'b0, 1'b0);
  endfunction

  function automatic logic [31:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 32'h0;
    if (r < 80) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  task automatic send_byte(input in_item_t it);
    out_item_t exp_item;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    exp_item = deframe_byte(it);
    expected_q.insert(expected_q.size(), exp_item);
    burst_left--;
    total_bytes++;
    if (exp_item.byte_role != ROLE_IGN) parsed_bytes++;
    if (exp_item.record_done) begin
      if (exp_item.record_good) records_good++;
      else records_bad++;
    end
    if (exp_item.truncated) truncations++;
  endtask

  task automatic send_log();
    foreach (log_bytes[i]) send_byte(log_bytes[i]);
    log_bytes.delete();
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic test_first_log_without_start();
    append_record(32'd1, 32'd0, 1'b0);
    log_bytes[log_bytes.size() - 1].log_end = 1'b1;
    send_log();
  endtask

  task automatic test_one_byte_log();
    push_byte(8'hFF, 1'b1, 1'b1);
    push_byte(8'h00, 1'b0, 1'b0);
    send_log();
  endtask

  task automatic test_checksum_mismatch();
    append_record(32'd0, 32'd1, 1'b1);
    log_bytes[0].log_start = 1'b1;
    push_byte(8'h5A, 1'b0, 1'b1);
    send_log();
  endtask

  task automatic test_random_logs();
    int          end_kind;
    int          cut;
    int          start_count;
    logic        drained;
    logic [31:0] big;
    start_count = parsed_bytes;
    drained     = 1'b0;
    while (parsed_bytes - start_count < RANDOM_BYTES) begin
      end_kind = $urandom_range(0, 99);
      if (end_kind < 6) begin
        repeat ($urandom_range(5, 30)) begin
          push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
                    $urandom_range(0, 9) == 0);
        end
      end else begin
        repeat ($urandom_range(1, 4)) append_record(pick_len(), pick_len(),
                                                    $urandom_range(0, 9) == 0);
        if (end_kind < 14) begin
          big = $urandom | 32'h0100_0000;
          push_le_word($urandom);
          if ($urandom_range(0, 1) == 0) begin
            push_le_word(big);
          end else begin
            push_le_word(32'h0);
            push_le_word(big);
          end
          repeat ($urandom_range(0, 6)) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          log_bytes[log_bytes.size() - 1].log_end = ($urandom_range(0, 3) != 0);
        end else if (end_kind < 35) begin
          cut = $urandom_range(1, log_bytes.size() - 1);
          while (log_bytes.size() > cut) void'(log_bytes.pop_back());
          log_bytes[log_bytes.size() - 1].log_end = 1'b1;
        end else if (end_kind < 80) begin
          log_bytes[log_bytes.size() - 1].log_end = 1'b1;
        end
        log_bytes[0].log_start = ($urandom_range(0, 19) != 0);
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            push_byte(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 3) == 0);
          end
        end
      end
      send_log();
      if (!drained && parsed_bytes - start_count >= RANDOM_BYTES / 2) begin
        wait_for_drain();
        drained = 1'b1;
      end else if ($urandom_range(0, 29) == 0) begin
        wait_for_drain();
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      errors++;
    end
  endfunction

  initial begin
    out_item_t exp_item;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected transaction: out_byte 'h%0h", out_data.out_byte);
          errors++;
        end else begin
          exp_item = expected_q.pop_front();
          check_field("out_byte", exp_item.out_byte, out_data.out_byte);
          check_field("byte_role", 8'(exp_item.byte_role), 8'(out_data.byte_role));
          check_field("record_done", 8'(exp_item.record_done), 8'(out_data.record_done));
          check_field("record_good", 8'(exp_item.record_good), 8'(out_data.record_good));
          check_field("truncated", 8'(exp_item.truncated), 8'(out_data.truncated));
        end
      end
    end
  end

  initial begin
    stall_mode_e mode;
    int          mode_left;
    int          tick;
    int          run_left;
    logic        run_stall;
    mode      = STALL_NONE;
    mode_left = 0;
    tick      = 0;
    run_left  = 0;
    run_stall = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = stall_mode_e'($urandom_range(0, 4));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      tick++;
      case (mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
        STALL_PERIODIC: out_stall <= ((tick % 5) < 2);
        default: begin
          if (run_left == 0) begin
            run_stall = ~run_stall;
            run_left  = run_stall ? $urandom_range(5, 20) : $urandom_range(1, 10);
          end
          run_left--;
          out_stall <= run_stall;
        end
      endcase
    end
  end

  initial begin
    while (cycle < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle++;
    end
    $display("kv_log_record_deframer_top: mismatch");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    clear_parse_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_first_log_without_start();
    test_one_byte_log();
    test_checksum_mismatch();
    wait_for_drain();
    test_random_logs();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d bytes (%0d parsed); records with good CRC %0d, with bad CRC %0d,",
             total_bytes, parsed_bytes, records_good, records_bad);
    $display("truncated logs %0d, under random gaps and receiver stalls", truncations);
    if (errors == 0) begin
      $display("kv_log_record_deframer_top: match");
    end else begin
      $display("kv_log_record_deframer_top: mismatch");
    end
    $finish;
  end

endmodule
